### rtl/spc_pkg.sv
// Types, constants and step functions shared by the sphere pair contact pipeline.
`default_nettype none
package spc_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned RAD_W     = 30;
  localparam int unsigned RSUM_W    = RAD_W + 1;
  localparam int unsigned REG_W     = 16;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned NORM_FRAC = 15;
  localparam int unsigned CORR_W    = 32;
  localparam int unsigned SQ_W      = 2 * RSUM_W;
  localparam int unsigned NUM_W     = RSUM_W + NORM_FRAC + 1;
  localparam int unsigned REM_W     = RSUM_W + 1;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned EF_W      = RSUM_W + REG_W;
  localparam int unsigned PROD_W    = EF_W + NORM_W;
  localparam int unsigned SQ_STAGES = 16;
  localparam int unsigned DV_STAGES = QUO_W / 2;

  localparam logic [0:0] REG_SLOP = 1'b0;
  localparam logic [0:0] REG_FRAC = 1'b1;

  localparam logic [REG_W-1:0] SLOP_RESET = 16'd66;
  localparam logic [REG_W-1:0] FRAC_RESET = 16'd98;
  localparam logic [NORM_W-1:0] NORM_ONE  = 16'h7FFF;

  typedef struct packed {
    logic                       miss;
    logic                       zero;
    logic [2:0]                 neg;
    logic [2:0][RSUM_W-1:0]     mag;
    logic [RSUM_W-1:0]          rsum;
    logic [RAD_W-1:0]           ra;
  } geo_t;

  typedef struct packed {
    logic                       miss;
    logic                       zero;
    logic [2:0]                 neg;
    logic [RSUM_W-1:0]          depth;
    logic [RSUM_W-1:0]          excess;
    logic [RSUM_W-1:0]          len;
  } hit_t;

  typedef struct packed {
    logic [NUM_W-1:0]           num;
    logic [REM_W-1:0]           rem;
    logic [QUO_W-1:0]           quo;
  } div_t;

  // One digit of the bit-pair square root: returns {v, r}.
  function automatic logic [127:0] sqrt_step(input logic [63:0] v, input logic [63:0] r,
                                             input logic [63:0] b);
    logic [63:0] t;
    t = r + b;
    if (v >= t) return {v - t, (r >> 1) + b};
    return {v, r >> 1};
  endfunction

  // One quotient bit of restoring division: returns {qbit, rem}.
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem, input logic nb,
                                              input logic [RSUM_W-1:0] len);
    logic [REM_W-1:0] t;
    t = {rem[REM_W-2:0], nb};
    if (t >= {1'b0, len}) return {1'b1, t - {1'b0, len}};
    return {1'b0, t};
  endfunction

endpackage
`default_nettype wire

### rtl/sphere_pair_contact_top.sv
// Sphere pair contact test: hit, depth, unit normal and positional correction.
`default_nettype none
// One sphere pair enters per cycle. The pipeline runs through the integer square
// root of the squared center distance (two result bits per stage, 16 stages)
// and the three normal dividers (two quotient bits per stage, 8 stages). The
// whole pipeline holds when the output register is full and not taken, so
// in_ready_o is low only then. A miss returns all zeros; coincident centers
// give depth radius_a and normal +x. The user must write configuration through
// cfg_we_i / cfg_addr_i / cfg_data_i only while idle; the block does not check.
module sphere_pair_contact_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_addr_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [31:0]   center_a_x_i,
  input  wire logic signed [31:0]   center_a_y_i,
  input  wire logic signed [31:0]   center_a_z_i,
  input  wire logic [29:0]          radius_a_i,
  input  wire logic signed [31:0]   center_b_x_i,
  input  wire logic signed [31:0]   center_b_y_i,
  input  wire logic signed [31:0]   center_b_z_i,
  input  wire logic [29:0]          radius_b_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      hit_o,
  output logic [30:0]               penetration_depth_o,
  output logic signed [15:0]        normal_x_o,
  output logic signed [15:0]        normal_y_o,
  output logic signed [15:0]        normal_z_o,
  output logic signed [31:0]        correction_x_o,
  output logic signed [31:0]        correction_y_o,
  output logic signed [31:0]        correction_z_o
);

  localparam int unsigned RW = spc_pkg::RSUM_W;
  localparam int unsigned SS = spc_pkg::SQ_STAGES;
  localparam int unsigned DS = spc_pkg::DV_STAGES;

  logic en;
  logic [15:0] slop_q, frac_q;

  // stage 1
  logic v1_q;
  logic signed [2:0][32:0] d1_q;
  logic [RW-1:0] rs1_q;
  logic [29:0] ra1_q;
  // stage 2
  logic v2_q, far2_q;
  logic [2:0] neg2_q;
  logic [2:0][RW-1:0] mag2_q;
  logic [2:0][spc_pkg::SQ_W-1:0] sq2_q;
  logic [spc_pkg::SQ_W-1:0] rr2_q;
  logic [RW-1:0] rs2_q;
  logic [29:0] ra2_q;
  // square root pipe
  logic [SS:0] sv_q;
  logic [SS:0][63:0] sval_q, sroot_q, sval_d, sroot_d;
  spc_pkg::geo_t [SS:0] sg_q;
  // divider pipe
  logic [DS:0] dv_q;
  spc_pkg::hit_t [DS:0] dh_q;
  spc_pkg::div_t [DS:0][2:0] dd_q, dd_d;
  // normal, product, output
  logic nv_q, nmiss_q, cv_q, cmiss_q;
  logic [2:0] nneg_q, cneg_q;
  logic [2:0][15:0] nmag_q, cmag_q;
  logic signed [2:0][15:0] nn_q, cn_q;
  logic [RW-1:0] ndepth_q, cdepth_q;
  logic [spc_pkg::EF_W-1:0] ef_q;
  logic [2:0][spc_pkg::PROD_W-1:0] p_q;

  logic out_v_q, hit_q;
  logic [30:0] depth_q;
  logic signed [2:0][15:0] n_q;
  logic signed [2:0][31:0] c_q;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slop_q <= spc_pkg::SLOP_RESET;
      frac_q <= spc_pkg::FRAC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        spc_pkg::REG_SLOP: slop_q <= cfg_data_i;
        spc_pkg::REG_FRAC: frac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; sv_q <= '0; dv_q <= '0;
      nv_q <= 1'b0; cv_q <= 1'b0; out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      sv_q    <= {sv_q[SS-1:0], v2_q};
      dv_q    <= {dv_q[DS-1:0], sv_q[SS]};
      nv_q    <= dv_q[DS];
      cv_q    <= nv_q;
      out_v_q <= cv_q;
    end
  end

  always_comb begin
    logic [127:0] t;
    sval_d  = sval_q;
    sroot_d = sroot_q;
    for (int i = 0; i < SS; i++) begin
      t = spc_pkg::sqrt_step(sval_q[i], sroot_q[i], 64'd1 << (62 - 4 * i));
      t = spc_pkg::sqrt_step(t[127:64], t[63:0], 64'd1 << (60 - 4 * i));
      sval_d[i+1]  = t[127:64];
      sroot_d[i+1] = t[63:0];
    end
  end

  always_comb begin
    logic [spc_pkg::REM_W:0] t;
    dd_d = dd_q;
    for (int i = 0; i < DS; i++) begin
      for (int k = 0; k < 3; k++) begin
        dd_d[i+1][k] = dd_q[i][k];
        t = spc_pkg::div_step(dd_q[i][k].rem, dd_q[i][k].num[15-2*i], dh_q[i].len);
        dd_d[i+1][k].quo[15-2*i] = t[spc_pkg::REM_W];
        t = spc_pkg::div_step(t[spc_pkg::REM_W-1:0], dd_q[i][k].num[14-2*i], dh_q[i].len);
        dd_d[i+1][k].quo[14-2*i] = t[spc_pkg::REM_W];
        dd_d[i+1][k].rem = t[spc_pkg::REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] m;
    logic far;
    logic [63:0] sum;
    logic [RW-1:0] dep, len;
    logic [32:0] q;
    if (en) begin
      // differences and radius sum
      d1_q[0] <= 33'(center_b_x_i) - 33'(center_a_x_i);
      d1_q[1] <= 33'(center_b_y_i) - 33'(center_a_y_i);
      d1_q[2] <= 33'(center_b_z_i) - 33'(center_a_z_i);
      rs1_q   <= {1'b0, radius_a_i} + {1'b0, radius_b_i};
      ra1_q   <= radius_a_i;

      // magnitudes, coarse reject and squares
      far = 1'b0;
      for (int k = 0; k < 3; k++) begin
        m = d1_q[k][32] ? 32'(-d1_q[k]) : d1_q[k][31:0];
        if (m > {1'b0, rs1_q}) far = 1'b1;
        neg2_q[k] <= d1_q[k][32];
        mag2_q[k] <= m[RW-1:0];
        sq2_q[k]  <= m[RW-1:0] * m[RW-1:0];
      end
      far2_q <= far;
      rr2_q <= rs1_q * rs1_q;
      rs2_q <= rs1_q;
      ra2_q <= ra1_q;

      // squared distance, fine reject, root seed
      sum = 64'(sq2_q[0]) + 64'(sq2_q[1]) + 64'(sq2_q[2]);
      sval_q[0]    <= sum;
      sroot_q[0]   <= '0;
      sg_q[0].miss <= far2_q || (sum > 64'(rr2_q));
      sg_q[0].zero <= (sum == 64'd0);
      sg_q[0].neg  <= neg2_q;
      sg_q[0].mag  <= mag2_q;
      sg_q[0].rsum <= rs2_q;
      sg_q[0].ra   <= ra2_q;
      for (int i = 0; i < SS; i++) begin
        sval_q[i+1]  <= sval_d[i+1];
        sroot_q[i+1] <= sroot_d[i+1];
        sg_q[i+1]    <= sg_q[i];
      end

      // depth, excess and divider seed
      len = sroot_q[SS][RW-1:0];
      dep = sg_q[SS].zero ? {1'b0, sg_q[SS].ra} : sg_q[SS].rsum - len;
      dh_q[0].miss   <= sg_q[SS].miss;
      dh_q[0].zero   <= sg_q[SS].zero;
      dh_q[0].neg    <= sg_q[SS].neg;
      dh_q[0].depth  <= dep;
      dh_q[0].excess <= (dep > RW'(slop_q)) ? dep - RW'(slop_q) : '0;
      dh_q[0].len    <= len;
      for (int k = 0; k < 3; k++) begin
        dd_q[0][k].num <= {sg_q[SS].mag[k], 15'd0} + spc_pkg::NUM_W'(len >> 1);
        dd_q[0][k].rem <= spc_pkg::REM_W'(({sg_q[SS].mag[k], 15'd0}
                           + spc_pkg::NUM_W'(len >> 1)) >> 16);
        dd_q[0][k].quo <= '0;
      end
      for (int i = 0; i < DS; i++) begin
        dh_q[i+1] <= dh_q[i];
        dd_q[i+1] <= dd_d[i+1];
      end

      // normals and excess times fraction
      nmiss_q  <= dh_q[DS].miss;
      ndepth_q <= dh_q[DS].depth;
      ef_q     <= dh_q[DS].excess * frac_q;
      for (int k = 0; k < 3; k++) begin
        if (dh_q[DS].zero) begin
          nneg_q[k] <= 1'b0;
          nmag_q[k] <= (k == 0) ? spc_pkg::NORM_ONE : 16'd0;
          nn_q[k]   <= (k == 0) ? spc_pkg::NORM_ONE : 16'sd0;
        end else if (dh_q[DS].neg[k]) begin
          nneg_q[k] <= 1'b1;
          nmag_q[k] <= dd_q[DS][k].quo;
          nn_q[k]   <= -dd_q[DS][k].quo;
        end else begin
          nneg_q[k] <= 1'b0;
          nmag_q[k] <= dd_q[DS][k].quo[15] ? spc_pkg::NORM_ONE : dd_q[DS][k].quo;
          nn_q[k]   <= dd_q[DS][k].quo[15] ? spc_pkg::NORM_ONE : dd_q[DS][k].quo;
        end
      end

      // correction products
      cmiss_q  <= nmiss_q;
      cdepth_q <= ndepth_q;
      cneg_q   <= nneg_q;
      cmag_q   <= nmag_q;
      cn_q     <= nn_q;
      for (int k = 0; k < 3; k++) p_q[k] <= ef_q * nmag_q[k];

      // round, saturate, zero on miss
      hit_q   <= !cmiss_q;
      depth_q <= cmiss_q ? '0 : cdepth_q;
      for (int k = 0; k < 3; k++) begin
        q = 33'((64'(p_q[k]) + (64'd1 << 30)) >> 31);
        if (cmiss_q) begin
          n_q[k] <= '0;
          c_q[k] <= '0;
        end else begin
          n_q[k] <= cn_q[k];
          if (cneg_q[k]) c_q[k] <= (q > 33'h080000000) ? 32'sh80000000 : -q[31:0];
          else           c_q[k] <= (q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
        end
      end
    end
  end

  assign out_valid_o         = out_v_q;
  assign hit_o               = hit_q;
  assign penetration_depth_o = depth_q;
  assign normal_x_o          = n_q[0];
  assign normal_y_o          = n_q[1];
  assign normal_z_o          = n_q[2];
  assign correction_x_o      = c_q[0];
  assign correction_y_o      = c_q[1];
  assign correction_z_o      = c_q[2];

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the sphere pair contact pipeline.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic signed [31:0] ax, ay, az;
    logic [29:0]        ra;
    logic signed [31:0] bx, by, bz;
    logic [29:0]        rb;
  } pair_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        depth;
    logic signed [15:0] nx, ny, nz;
    logic signed [31:0] cx, cy, cz;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_addr_i = spc_pkg::REG_SLOP;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pair_t cur = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  contact_t res;

  logic [15:0] slop_q = spc_pkg::SLOP_RESET;
  logic [15:0] frac_q = spc_pkg::FRAC_RESET;
  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_send = 1'b0;

  sphere_pair_contact_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .center_a_x_i(cur.ax), .center_a_y_i(cur.ay), .center_a_z_i(cur.az),
    .radius_a_i(cur.ra),
    .center_b_x_i(cur.bx), .center_b_y_i(cur.by), .center_b_z_i(cur.bz),
    .radius_b_i(cur.rb),
    .out_valid_o, .out_ready_i,
    .hit_o(res.hit), .penetration_depth_o(res.depth),
    .normal_x_o(res.nx), .normal_y_o(res.ny), .normal_z_o(res.nz),
    .correction_x_o(res.cx), .correction_y_o(res.cy), .correction_z_o(res.cz)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Append to the tail of the pending and expected queues.
  function automatic void queue_pair(input pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  function automatic void queue_contact(input contact_t c);
    expected_contacts.insert(expected_contacts.size(), c);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] unit_part(input logic signed [63:0] d,
                                                   input logic [63:0] len);
    logic [63:0] m, q;
    m = d < 0 ? -d : d;
    q = ((m << 15) + (len >> 1)) / len;
    if (d < 0) return q > 32768 ? 16'sh8000 : 16'(-q);
    return q > 32767 ? 16'sd32767 : 16'(q);
  endfunction

  function automatic logic signed [31:0] push_part(input logic [63:0] excess,
                                                   input logic signed [15:0] n);
    logic [63:0] m, q;
    m = n < 0 ? -n : n;
    q = (excess * frac_q * m + (64'd1 << 30)) >> 31;
    if (n < 0) return q > 64'h8000_0000 ? 32'sh8000_0000 : 32'(-q);
    return q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  function automatic contact_t contact_of(input pair_t p);
    contact_t c;
    logic signed [63:0] d[3];
    logic [63:0] m[3];
    logic [63:0] rsum, dist2, len, depth, excess;
    logic signed [15:0] n[3];
    c = '0;
    rsum = 64'(p.ra) + 64'(p.rb);
    d[0] = 64'(p.bx) - 64'(p.ax);
    d[1] = 64'(p.by) - 64'(p.ay);
    d[2] = 64'(p.bz) - 64'(p.az);
    for (int k = 0; k < 3; k++) begin
      m[k] = d[k] < 0 ? -d[k] : d[k];
      if (m[k] > rsum) return c;
    end
    dist2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    if (dist2 > rsum * rsum) return c;
    if (dist2 == 0) begin
      depth = 64'(p.ra);
      n[0] = 16'sd32767; n[1] = 16'sd0; n[2] = 16'sd0;
    end else begin
      len = int_sqrt(dist2);
      depth = rsum - len;
      for (int k = 0; k < 3; k++) n[k] = unit_part(d[k], len);
    end
    excess = depth > 64'(slop_q) ? depth - 64'(slop_q) : 64'd0;
    c.hit = 1'b1;
    c.depth = depth[30:0];
    c.nx = n[0]; c.ny = n[1]; c.nz = n[2];
    c.cx = push_part(excess, n[0]);
    c.cy = push_part(excess, n[1]);
    c.cz = push_part(excess, n[2]);
    return c;
  endfunction

  // Driver: hold the payload until the transfer completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) queue_contact(contact_of(cur));
        if (pending_pairs.size() > 0 && !hold_send && (quiet || $urandom_range(99) >= 27)) begin
          cur <= pending_pairs.pop_front();
          in_valid_i <= 1'b1;
        end else in_valid_i <= 1'b0;
      end
      out_ready_i <= quiet || $urandom_range(99) >= 27;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_contacts.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        contact_t e;
        e = expected_contacts.pop_front();
        if (e.hit !== res.hit) begin $error("hit exp %0d got %0d", e.hit, res.hit); errors++; end
        if (e.depth !== res.depth) begin
          $error("penetration_depth exp %0d got %0d", e.depth, res.depth); errors++;
        end
        if (e.nx !== res.nx) begin $error("normal_x exp %0d got %0d", e.nx, res.nx); errors++; end
        if (e.ny !== res.ny) begin $error("normal_y exp %0d got %0d", e.ny, res.ny); errors++; end
        if (e.nz !== res.nz) begin $error("normal_z exp %0d got %0d", e.nz, res.nz); errors++; end
        if (e.cx !== res.cx) begin
          $error("correction_x exp %0d got %0d", e.cx, res.cx); errors++;
        end
        if (e.cy !== res.cy) begin
          $error("correction_y exp %0d got %0d", e.cy, res.cy); errors++;
        end
        if (e.cz !== res.cz) begin
          $error("correction_z exp %0d got %0d", e.cz, res.cz); errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'sh8000_0000 + $urandom_range(3);
      2: return 32'sh7FFF_FFFF - $urandom_range(3);
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  // Pair placed so that it tends to overlap or nearly touch.
  function automatic pair_t near_pair();
    pair_t p;
    int unsigned span;
    span = $urandom_range(3) == 0 ? 32'h3FFF_FFFF : $urandom_range(20'hFFFFF, 16);
    p.ra = 30'($urandom_range(span));
    p.rb = 30'($urandom_range(span));
    p.ax = rand_coord();
    p.ay = rand_coord();
    p.az = rand_coord();
    p.bx = p.ax + $signed($urandom_range(2 * span) - span);
    p.by = p.ay + $signed($urandom_range(span) - span / 2);
    p.bz = p.az + $signed($urandom_range(span / 2) - span / 4);
    return p;
  endfunction

  // Settle past the edge so queue and valid updates of that edge are seen together.
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_pairs.size() != 0 || in_valid_i || expected_contacts.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == spc_pkg::REG_SLOP) slop_q = val; else frac_q = val;
  endtask

  function automatic pair_t make_pair(input int ax, ay, az, input int unsigned ra,
                                      input int bx, by, bz, input int unsigned rb);
    pair_t p;
    p.ax = ax; p.ay = ay; p.az = az; p.ra = 30'(ra);
    p.bx = bx; p.by = by; p.bz = bz; p.rb = 30'(rb);
    return p;
  endfunction

  initial begin
    pair_t p;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: coincident, touching, miss, extremes, below slop, axis normals
    queue_pair(make_pair(0, 0, 0, 32'h10000, 0, 0, 0, 32'h20000));
    queue_pair(make_pair(0, 0, 0, 32'h10000, 32'h20000, 0, 0, 32'h10000));
    queue_pair(make_pair(0, 0, 0, 32'h10000, 32'h20001, 0, 0, 32'h10000));
    queue_pair(make_pair(0, 0, 0, 32'h10000, 0, -32'h18000, 0, 32'h10000));
    queue_pair(make_pair(5, 5, 5, 32'h10000, 5, 5, 32'h18000, 32'h10000));
    queue_pair(make_pair(0, 0, 0, 32'h10000, 32'h1FFF0, 0, 0, 32'h10000));
    queue_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         32'h3FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'h3FFF_FFFF));
    queue_pair(make_pair(32'sh8000_0000, 0, 0, 32'h3FFF_FFFF,
                         32'sh8000_0000 + 32'h3FFF_0000, 32'h1000_0000,
                         -32'h1000_0000, 32'h3FFF_FFFF));
    queue_pair(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'h3FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'h3FFF_FFFF));
    queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    queue_pair(make_pair(0, 0, 0, 0, 1, 0, 0, 0));
    queue_pair(make_pair(100, 100, 100, 32'h8000, 32'h7000, -32'h7000, 32'h7000,
                         32'h8000));
    drain();
    write_reg(spc_pkg::REG_SLOP, 16'd0);
    write_reg(spc_pkg::REG_FRAC, 16'hFFFF);
    for (int i = 0; i < 12; i++) queue_pair(near_pair());
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(spc_pkg::REG_SLOP, 16'hFFFF);
          write_reg(spc_pkg::REG_FRAC, 16'd0);
        end
        1: begin
          write_reg(spc_pkg::REG_SLOP, 16'($urandom));
          write_reg(spc_pkg::REG_FRAC, 16'($urandom));
        end
        2: begin
          write_reg(spc_pkg::REG_SLOP, 16'd1);
          write_reg(spc_pkg::REG_FRAC, 16'h8000);
        end
        default: begin
          write_reg(spc_pkg::REG_SLOP, 16'($urandom_range(500)));
          write_reg(spc_pkg::REG_FRAC, 16'($urandom));
        end
      endcase
      quiet = (ph == 2);
      for (int i = 0; i < 185; i++) begin
        if ($urandom_range(4) == 0) begin
          p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
          p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
          p.ra = 30'($urandom); p.rb = 30'($urandom);
        end else p = near_pair();
        queue_pair(p);
      end
      if (ph == 1) begin
        // pause the sender until the pipeline empties
        wait (pending_pairs.size() < 90);
        hold_send = 1'b1;
        @(posedge clk_i);
        #1;
        wait (!in_valid_i && expected_contacts.size() == 0);
        hold_send = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

### sphere_pair_contact_top.f
rtl/spc_pkg.sv
rtl/sphere_pair_contact_top.sv
verif/testbench.sv
